/* rtl/core/sclr_pkg.sv */
// shared types and constants for the cubic sensor linearizer with rate output
// no dependencies; used by sclr_serial_unit and sensor_cubic_linearize_rate
package sclr_pkg;

  // field widths
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // serial unit geometry
  localparam int unsigned MUL_A_W   = 34;
  localparam int unsigned RES_W     = 66;
  localparam int unsigned DIVD_W    = 65;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned MUL_STEPS = 32;
  localparam int unsigned DIV_STEPS = 65;

  // polynomial accumulator width
  localparam int unsigned SUM_W = 50;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TPS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTV = 3'd5;

  localparam logic [DATA_W-1:0] TPS_RESET      = 32'd1000000;
  localparam logic [DATA_W-1:0] MIN_INTV_RESET = 32'd100000;

  typedef enum logic {
    SCLR_OP_MUL,
    SCLR_OP_DIV
  } sclr_op_t;

  // request to the serial unit
  typedef struct packed {
    logic     start;
    sclr_op_t op;
  } sclr_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_XX,
    ST_X2X,
    ST_A1,
    ST_A2,
    ST_A3,
    ST_DECIDE,
    ST_MRATE,
    ST_DRATE,
    ST_FINISH
  } sclr_state_t;

endpackage

/* rtl/core/sclr_serial_unit.sv */
// bit-serial shift-add multiplier and restoring divider sharing one set of registers
// depends on sclr_pkg
module sclr_serial_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sclr_pkg::sclr_req_t          req,
  input  logic [sclr_pkg::RES_W-1:0]   opnd_a,
  input  logic [sclr_pkg::DATA_W-1:0]  opnd_b,
  output logic                         done,
  output logic [sclr_pkg::RES_W-1:0]   result
);

  logic                               busy_r, busy_nxt;
  logic                               done_r, done_nxt;
  sclr_pkg::sclr_op_t                 op_r, op_nxt;
  logic [sclr_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [sclr_pkg::RES_W-1:0]         acc_r, acc_nxt;
  logic [sclr_pkg::MUL_A_W-1:0]       a_r, a_nxt;
  logic [sclr_pkg::DATA_W-1:0]        b_r, b_nxt;
  logic [sclr_pkg::DATA_W-1:0]        rem_r, rem_nxt;

  logic signed [sclr_pkg::MUL_A_W:0]  psum;
  logic [sclr_pkg::DATA_W:0]          trial;
  logic [sclr_pkg::DATA_W:0]          diff;
  logic                               ge;
  logic                               last;

  // one multiplier bit or one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;

    psum  = $signed({acc_r[sclr_pkg::RES_W-1], acc_r[sclr_pkg::RES_W-1:sclr_pkg::DATA_W]})
          + (b_r[0] ? $signed({a_r[sclr_pkg::MUL_A_W-1], a_r})
                    : $signed({(sclr_pkg::MUL_A_W+1){1'b0}}));
    trial = {rem_r, acc_r[sclr_pkg::DIVD_W-1]};
    diff  = trial - {1'b0, b_r};
    ge    = (trial >= {1'b0, b_r});

    if (op_r == sclr_pkg::SCLR_OP_MUL) begin
      last = (cnt_r == sclr_pkg::CNT_W'(sclr_pkg::MUL_STEPS - 1));
    end else begin
      last = (cnt_r == sclr_pkg::CNT_W'(sclr_pkg::DIV_STEPS - 1));
    end

    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = '0;
      a_nxt    = opnd_a[sclr_pkg::MUL_A_W-1:0];
      b_nxt    = opnd_b;
      rem_nxt  = '0;
      if (req.op == sclr_pkg::SCLR_OP_MUL) begin
        acc_nxt = '0;
      end else begin
        acc_nxt = opnd_a;
      end
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (op_r == sclr_pkg::SCLR_OP_MUL) begin
        // add into the high half, then shift the pair right
        acc_nxt = {psum, acc_r[sclr_pkg::DATA_W-1:1]};
        b_nxt   = {1'b0, b_r[sclr_pkg::DATA_W-1:1]};
      end else begin
        rem_nxt = ge ? diff[sclr_pkg::DATA_W-1:0] : trial[sclr_pkg::DATA_W-1:0];
        acc_nxt = {1'b0, acc_r[sclr_pkg::DIVD_W-2:0], ge};
      end
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= sclr_pkg::SCLR_OP_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

/* rtl/core/sensor_cubic_linearize_rate.sv */
// top level: cubic sensor linearization in Q16.16 with rate of change per second
// depends on sclr_pkg and sclr_serial_unit
//
// Each accepted word (sample_value, tick_now) yields exactly one result word with the
// linearized temperature, the held rate and a flag telling whether this sample
// recomputed the rate. All products and the rate division run one bit per cycle
// through a single shared serial unit: five 32-step multiplies for the polynomial,
// then, only when the rate is recomputed, one 32-step multiply and one 65-step
// divide. The next word is taken only after the result of the last has entered the
// output register, and later when the previous result is still stalled there.
// The output register lets the next word be taken while a result still waits.
// Configuration is write-only, always ready, and must be written while idle.
module sensor_cubic_linearize_rate (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [sclr_pkg::SAMPLE_W-1:0]    in_sample_value,
  input  logic [sclr_pkg::DATA_W-1:0]      in_tick_now,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [sclr_pkg::DATA_W-1:0] out_temperature,
  output logic signed [sclr_pkg::DATA_W-1:0] out_temperature_rate,
  output logic                             out_rate_updated,
  // configuration channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sclr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sclr_pkg::DATA_W-1:0]      cfg_data
);

  localparam logic signed [sclr_pkg::SUM_W-1:0] SAT_HI = sclr_pkg::SUM_W'(32'sh7fffffff);
  localparam logic signed [sclr_pkg::SUM_W-1:0] SAT_LO = -sclr_pkg::SUM_W'(64'sh80000000);

  // configuration registers
  logic [sclr_pkg::DATA_W-1:0] a0_r, a1_r, a2_r, a3_r, tps_r, min_r;

  // state and working registers
  sclr_pkg::sclr_state_t             state_r, state_nxt;
  logic [19:0]                       x_r, x_nxt;
  logic [23:0]                       x2_r, x2_nxt;
  logic [27:0]                       x3_r, x3_nxt;
  logic signed [sclr_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [sclr_pkg::DATA_W-1:0]       tick_r, tick_nxt;
  logic [sclr_pkg::DATA_W-1:0]       elapsed_r, elapsed_nxt;
  logic [sclr_pkg::DATA_W-1:0]       temp_r, temp_nxt;
  logic                              neg_r, neg_nxt;
  logic                              upd_r, upd_nxt;
  logic [sclr_pkg::DATA_W-1:0]       last_tick_r, last_tick_nxt;
  logic [sclr_pkg::DATA_W-1:0]       last_temp_r, last_temp_nxt;
  logic [sclr_pkg::DATA_W-1:0]       held_rate_r, held_rate_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [sclr_pkg::DATA_W-1:0]       out_temp_r, out_temp_nxt;
  logic [sclr_pkg::DATA_W-1:0]       out_rate_r, out_rate_nxt;
  logic                              out_upd_r, out_upd_nxt;

  // serial unit connection
  sclr_pkg::sclr_req_t               req;
  logic [sclr_pkg::RES_W-1:0]        opnd_a;
  logic [sclr_pkg::DATA_W-1:0]       opnd_b;
  logic                              unit_done;
  logic [sclr_pkg::RES_W-1:0]        unit_res;

  // combinational helpers
  logic signed [sclr_pkg::SUM_W-1:0] term;
  logic [sclr_pkg::DATA_W-1:0]       temp_sat;
  logic signed [33:0]                delta;
  logic [32:0]                       mag_abs;
  logic                              do_upd;
  logic [32:0]                       limit;
  logic [32:0]                       mag;
  logic [32:0]                       mag_signed;
  logic                              accept;
  logic                              out_free;

  sclr_serial_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .opnd_a (opnd_a),
    .opnd_b (opnd_b),
    .done   (unit_done),
    .result (unit_res)
  );

  assign accept   = in_valid && (state_r == sclr_pkg::ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // sequencer, datapath steps and output register
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    x2_nxt        = x2_r;
    x3_nxt        = x3_r;
    sum_nxt       = sum_r;
    tick_nxt      = tick_r;
    elapsed_nxt   = elapsed_r;
    temp_nxt      = temp_r;
    neg_nxt       = neg_r;
    upd_nxt       = upd_r;
    last_tick_nxt = last_tick_r;
    last_temp_nxt = last_temp_r;
    held_rate_nxt = held_rate_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_temp_nxt  = out_temp_r;
    out_rate_nxt  = out_rate_r;
    out_upd_nxt   = out_upd_r;
    req.start     = 1'b0;
    req.op        = sclr_pkg::SCLR_OP_MUL;
    opnd_a        = '0;
    opnd_b        = '0;

    // floor(product / 2^16) is the arithmetic shift of the signed product
    term = $signed(unit_res[sclr_pkg::RES_W-1:16]);

    // saturated temperature from the accumulated polynomial
    if (sum_r > SAT_HI) begin
      temp_sat = 32'h7fffffff;
    end else if (sum_r < SAT_LO) begin
      temp_sat = 32'h80000000;
    end else begin
      temp_sat = sum_r[sclr_pkg::DATA_W-1:0];
    end

    delta   = $signed({{2{temp_sat[31]}}, temp_sat})
            - $signed({{2{last_temp_r[31]}}, last_temp_r});
    mag_abs = delta[33] ? 33'(-delta) : delta[32:0];
    do_upd  = (elapsed_r != '0) && (elapsed_r >= min_r);

    // rate magnitude clamp, one more on the negative side
    limit = neg_r ? 33'h080000000 : 33'h07fffffff;
    if (unit_res[sclr_pkg::DIVD_W-1:0] > {32'd0, limit}) begin
      mag = limit;
    end else begin
      mag = unit_res[32:0];
    end
    mag_signed = neg_r ? (~mag + 33'd1) : mag;

    case (state_r)
      sclr_pkg::ST_IDLE: begin
        if (in_valid) begin
          x_nxt       = {in_sample_value, 4'b0000};
          tick_nxt    = in_tick_now;
          elapsed_nxt = in_tick_now - last_tick_r;
          req.start   = 1'b1;
          opnd_a      = {46'd0, in_sample_value, 4'b0000};
          opnd_b      = {12'd0, in_sample_value, 4'b0000};
          state_nxt   = sclr_pkg::ST_XX;
        end
      end
      sclr_pkg::ST_XX: begin
        if (unit_done) begin
          x2_nxt    = unit_res[39:16];
          req.start = 1'b1;
          opnd_a    = {42'd0, unit_res[39:16]};
          opnd_b    = {12'd0, x_r};
          state_nxt = sclr_pkg::ST_X2X;
        end
      end
      sclr_pkg::ST_X2X: begin
        if (unit_done) begin
          x3_nxt    = unit_res[43:16];
          sum_nxt   = sclr_pkg::SUM_W'($signed(a0_r));
          req.start = 1'b1;
          opnd_a    = {{34{a1_r[31]}}, a1_r};
          opnd_b    = {12'd0, x_r};
          state_nxt = sclr_pkg::ST_A1;
        end
      end
      sclr_pkg::ST_A1: begin
        if (unit_done) begin
          sum_nxt   = sum_r + term;
          req.start = 1'b1;
          opnd_a    = {{34{a2_r[31]}}, a2_r};
          opnd_b    = {8'd0, x2_r};
          state_nxt = sclr_pkg::ST_A2;
        end
      end
      sclr_pkg::ST_A2: begin
        if (unit_done) begin
          sum_nxt   = sum_r + term;
          req.start = 1'b1;
          opnd_a    = {{34{a3_r[31]}}, a3_r};
          opnd_b    = {4'd0, x3_r};
          state_nxt = sclr_pkg::ST_A3;
        end
      end
      sclr_pkg::ST_A3: begin
        if (unit_done) begin
          sum_nxt   = sum_r + term;
          state_nxt = sclr_pkg::ST_DECIDE;
        end
      end
      sclr_pkg::ST_DECIDE: begin
        temp_nxt = temp_sat;
        upd_nxt  = do_upd;
        neg_nxt  = delta[33];
        if (do_upd) begin
          req.start = 1'b1;
          opnd_a    = {33'd0, mag_abs};
          opnd_b    = tps_r;
          state_nxt = sclr_pkg::ST_MRATE;
        end else begin
          state_nxt = sclr_pkg::ST_FINISH;
        end
      end
      sclr_pkg::ST_MRATE: begin
        if (unit_done) begin
          req.start = 1'b1;
          req.op    = sclr_pkg::SCLR_OP_DIV;
          opnd_a    = {1'b0, unit_res[sclr_pkg::DIVD_W-1:0]};
          opnd_b    = elapsed_r;
          state_nxt = sclr_pkg::ST_DRATE;
        end
      end
      sclr_pkg::ST_DRATE: begin
        if (unit_done) begin
          held_rate_nxt = mag_signed[sclr_pkg::DATA_W-1:0];
          last_tick_nxt = tick_r;
          last_temp_nxt = temp_r;
          state_nxt     = sclr_pkg::ST_FINISH;
        end
      end
      sclr_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_temp_nxt  = temp_r;
          out_rate_nxt  = held_rate_r;
          out_upd_nxt   = upd_r;
          state_nxt     = sclr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sclr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sclr_pkg::ST_IDLE;
      last_tick_r <= '0;
      last_temp_r <= '0;
      held_rate_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_tick_r <= last_tick_nxt;
      last_temp_r <= last_temp_nxt;
      held_rate_r <= held_rate_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r        <= x_nxt;
    x2_r       <= x2_nxt;
    x3_r       <= x3_nxt;
    sum_r      <= sum_nxt;
    tick_r     <= tick_nxt;
    elapsed_r  <= elapsed_nxt;
    temp_r     <= temp_nxt;
    neg_r      <= neg_nxt;
    upd_r      <= upd_nxt;
    out_temp_r <= out_temp_nxt;
    out_rate_r <= out_rate_nxt;
    out_upd_r  <= out_upd_nxt;
  end

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a0_r  <= '0;
      a1_r  <= '0;
      a2_r  <= '0;
      a3_r  <= '0;
      tps_r <= sclr_pkg::TPS_RESET;
      min_r <= sclr_pkg::MIN_INTV_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        sclr_pkg::REG_COEF_A0:  a0_r  <= cfg_data;
        sclr_pkg::REG_COEF_A1:  a1_r  <= cfg_data;
        sclr_pkg::REG_COEF_A2:  a2_r  <= cfg_data;
        sclr_pkg::REG_COEF_A3:  a3_r  <= cfg_data;
        sclr_pkg::REG_TPS:      tps_r <= cfg_data;
        sclr_pkg::REG_MIN_INTV: min_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready            = 1'b1;
  assign in_stall             = (state_r != sclr_pkg::ST_IDLE) || !accept;
  assign out_valid            = out_valid_r;
  assign out_temperature      = out_temp_r;
  assign out_temperature_rate = out_rate_r;
  assign out_rate_updated     = out_upd_r;

endmodule

/* tb/tb_sensor_cubic_linearize_rate.sv */
// testbench for sensor_cubic_linearize_rate: cubic linearization and rate-of-change checks
// depends on sclr_pkg and the sensor_cubic_linearize_rate rtl; self-contained otherwise
`timescale 1ns / 100ps

// keeps its own copy of coefficients and rate state, queues predicted result words
class linearize_scoreboard;
  logic [31:0] coef [4];
  logic [31:0] tps;
  logic [31:0] min_intv;
  logic [31:0] last_tick;
  logic [31:0] last_temp;
  logic [31:0] held_rate;
  logic [31:0] exp_temp [$];
  logic [31:0] exp_rate [$];
  logic        exp_upd [$];
  int          mismatches;

  function new();
    for (int i = 0; i < 4; i++) coef[i] = '0;
    tps = sclr_pkg::TPS_RESET;
    min_intv = sclr_pkg::MIN_INTV_RESET;
    last_tick = '0;
    last_temp = '0;
    held_rate = '0;
    mismatches = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      sclr_pkg::REG_COEF_A0: coef[0] = val;
      sclr_pkg::REG_COEF_A1: coef[1] = val;
      sclr_pkg::REG_COEF_A2: coef[2] = val;
      sclr_pkg::REG_COEF_A3: coef[3] = val;
      sclr_pkg::REG_TPS: tps = val;
      sclr_pkg::REG_MIN_INTV: min_intv = val;
      default: ;
    endcase
  endfunction

  // arithmetic shift is floor division by 2^16
  function logic signed [127:0] poly_term(logic [31:0] a, logic [63:0] xp);
    logic signed [127:0] p;
    p = $signed({{96{a[31]}}, a}) * $signed({64'd0, xp});
    return p >>> 16;
  endfunction

  function logic signed [63:0] sat(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 64'sd2147483647;
    if (v < -128'sd2147483648) return -64'sd2147483648;
    return v[63:0];
  endfunction

  function void note_sample(logic [15:0] sample, logic [31:0] now);
    logic [63:0] x, x2, x3;
    logic signed [127:0] sum, delta, mag, q;
    logic signed [63:0] temp;
    logic signed [63:0] rate64;
    logic [31:0] elapsed;
    logic upd;
    x = {44'd0, sample, 4'd0};
    x2 = (x * x) >> 16;
    x3 = (x2 * x) >> 16;
    sum = $signed({{96{coef[0][31]}}, coef[0]});
    sum = sum + poly_term(coef[1], x) + poly_term(coef[2], x2) + poly_term(coef[3], x3);
    temp = sat(sum);
    elapsed = now - last_tick;
    upd = 1'b0;
    if (elapsed != 0 && elapsed >= min_intv) begin
      delta = temp - $signed({{96{last_temp[31]}}, last_temp});
      mag = (delta < 0) ? -delta : delta;
      q = (mag * $signed({96'd0, tps})) / $signed({96'd0, elapsed});
      if (delta < 0) q = -q;
      rate64 = sat(q);
      held_rate = rate64[31:0];
      last_tick = now;
      last_temp = temp[31:0];
      upd = 1'b1;
    end
    exp_temp.push_back(temp[31:0]);
    exp_rate.push_back(held_rate);
    exp_upd.push_back(upd);
  endfunction

  function void check_result(logic [31:0] t, logic [31:0] r, logic u);
    logic [31:0] et, er;
    logic eu;
    if (exp_temp.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word t=%h r=%h u=%b", t, r, u);
      return;
    end
    et = exp_temp.pop_front();
    er = exp_rate.pop_front();
    eu = exp_upd.pop_front();
    if (t !== et || r !== er || u !== eu) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp t=%h r=%h u=%b got t=%h r=%h u=%b", et, er, eu, t, r, u);
    end
  endfunction

  function int pending();
    return exp_temp.size();
  endfunction
endclass

module tb_sensor_cubic_linearize_rate;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [sclr_pkg::SAMPLE_W-1:0] in_sample_value;
  logic [sclr_pkg::DATA_W-1:0] in_tick_now;
  logic out_valid, out_stall;
  logic signed [sclr_pkg::DATA_W-1:0] out_temperature, out_temperature_rate;
  logic out_rate_updated;
  logic cfg_valid, cfg_ready;
  logic [sclr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sclr_pkg::DATA_W-1:0] cfg_data;

  linearize_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  logic [31:0] tick_cursor;

  sensor_cubic_linearize_rate u_top (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall limit
  initial begin
    #400ms;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stall, check each accepted word
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result(out_temperature, out_temperature_rate, out_rate_updated);
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one word, with an optional random gap first
  task automatic send_sample(logic [15:0] s, logic [31:0] t);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_sample_value <= s;
    in_tick_now <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(s, t);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (sb.pending() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(32'h3ffff) - 32'h1ffff;
      default: return $urandom;
    endcase
  endfunction

  // mostly ticks that clear the interval, some equal or short steps
  task automatic random_phase(int count);
    logic [31:0] step;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: step = 0;
        1: step = $urandom;
        2: step = $urandom_range(sb.min_intv > 1 ? sb.min_intv - 1 : 1);
        default: step = sb.min_intv + $urandom_range(3);
      endcase
      tick_cursor = tick_cursor + step;
      send_sample($urandom_range(16'hffff), tick_cursor);
    end
  endtask

  task automatic set_config(int mode);
    for (int k = 0; k < 4; k++) write_cfg(k[2:0], rand_coef());
    case (mode)
      0: begin
        write_cfg(sclr_pkg::REG_TPS, 32'hffffffff);
        write_cfg(sclr_pkg::REG_MIN_INTV, 32'd1);
      end
      1: begin
        write_cfg(sclr_pkg::REG_TPS, 32'd1);
        write_cfg(sclr_pkg::REG_MIN_INTV, 32'd4);
      end
      2: begin
        write_cfg(sclr_pkg::REG_TPS, 32'd0);
        write_cfg(sclr_pkg::REG_MIN_INTV, 32'd0);
      end
      default: begin
        write_cfg(sclr_pkg::REG_TPS, $urandom);
        write_cfg(sclr_pkg::REG_MIN_INTV, $urandom_range(1000) + 1);
      end
    endcase
  endtask

  // stimulus
  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_value = '0;
    in_tick_now = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 37;
    recv_idle_pct = 57;
    tick_cursor = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset config, then extremes, same tick, wrap, zero tps
    send_sample(16'h0000, 32'd0);
    send_sample(16'hffff, 32'd100000);
    drain();
    write_cfg(sclr_pkg::REG_COEF_A0, 32'h7fffffff);
    write_cfg(sclr_pkg::REG_COEF_A1, 32'h7fffffff);
    write_cfg(sclr_pkg::REG_COEF_A2, 32'h7fffffff);
    write_cfg(sclr_pkg::REG_COEF_A3, 32'h7fffffff);
    write_cfg(3'd7, 32'h12345678);
    write_cfg(sclr_pkg::REG_MIN_INTV, 32'd1);
    write_cfg(sclr_pkg::REG_TPS, 32'hffffffff);
    send_sample(16'hffff, 32'd100001);
    send_sample(16'hffff, 32'd100001);
    send_sample(16'h0000, 32'hffffffff);
    send_sample(16'h8000, 32'd5);
    drain();
    for (int k = 0; k < 4; k++) write_cfg(k[2:0], 32'h80000000);
    write_cfg(sclr_pkg::REG_TPS, 32'd0);
    write_cfg(sclr_pkg::REG_MIN_INTV, 32'hffffffff);
    send_sample(16'hffff, 32'd4);
    send_sample(16'h0001, 32'd3);
    drain();
    write_cfg(sclr_pkg::REG_MIN_INTV, 32'd0);
    send_sample(16'h7fff, 32'd3);
    send_sample(16'h1234, 32'd9);
    drain();
    tick_cursor = 32'd9;

    // random, three idling regimes, several configs each
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 57 : 0;
      recv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 37 : 0;
      for (int m = 0; m < 4; m++) begin
        set_config(m);
        random_phase(128);
        drain();
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
